[rtl/bmmh_pkg.sv]
// shared types, constants and helpers for the binned mean / min / max history core
// no dependencies; used by bmmh_div.sv and binned_mean_min_max_history_core.sv
package bmmh_pkg;

   // history store geometry
   localparam int BINS    = 256;
   localparam int BIN_AW  = $clog2(BINS);
   localparam int SCAN_W  = BIN_AW + 1;

   // field widths
   localparam int TEMP_W  = 10;
   localparam int SPB_W   = 16;
   localparam int BIN_W   = 8;
   // magnitude of 4 * bin * count + sample
   localparam int ACC_W   = 27;

   localparam logic [SPB_W-1:0]        SPB_RESET = 16'd338;
   localparam logic signed [BIN_W-1:0] UNDEF_BIN = -8'sd128;
   localparam logic signed [BIN_W-1:0] BIN_MAX   = 8'sd127;

   // item sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MULT,
      ST_DIVIDE,
      ST_WRITE,
      ST_SEED,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // divider request / response
   typedef struct packed {
      logic             start;
      logic [ACC_W-1:0] dividend;
      logic [SPB_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [ACC_W-1:0] quotient;
   } div_rsp_type;

   // sample / 4 truncated toward zero, clipped to -127..127
   function automatic logic signed [BIN_W-1:0] seed_bin(input logic signed [TEMP_W-1:0] t);
      logic [TEMP_W-1:0] mag;
      logic [BIN_W-1:0]  q;
      logic [BIN_W-1:0]  qs;
      mag = t[TEMP_W-1] ? (~t + 1'b1) : t;
      q   = mag[TEMP_W-1:2];
      qs  = (q > BIN_W'(BIN_MAX)) ? BIN_W'(BIN_MAX) : q;
      return t[TEMP_W-1] ? $signed(~qs + 1'b1) : $signed(qs);
   endfunction

endpackage

[rtl/bmmh_div.sv]
// iterative unsigned restoring divider, one quotient bit per cycle
// depends on bmmh_pkg for widths and the request / response structs
module bmmh_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bmmh_pkg::div_req_type req,
   output bmmh_pkg::div_rsp_type rsp
);

   localparam int CNT_W = $clog2(bmmh_pkg::ACC_W);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [bmmh_pkg::ACC_W-1:0]      dq_ff, dq_in;
   logic [bmmh_pkg::SPB_W-1:0]      rem_ff, rem_in;
   logic [bmmh_pkg::SPB_W-1:0]      dvs_ff, dvs_in;
   logic [bmmh_pkg::SPB_W:0]        trial;
   logic                            fits;

   // one shift / subtract step
   always_comb begin
      trial   = {rem_ff, dq_ff[bmmh_pkg::ACC_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dq_in   = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? bmmh_pkg::SPB_W'(trial - {1'b0, dvs_ff})
                       : trial[bmmh_pkg::SPB_W-1:0];
         dq_in  = {dq_ff[bmmh_pkg::ACC_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(bmmh_pkg::ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = dq_ff;

endmodule

[rtl/binned_mean_min_max_history_core.sv]
// binned temperature history: running bin means in a ram, min / max scan per item
// depends on bmmh_pkg and bmmh_div
//
// usage:
//   req channel carries one temperature sample (tenths of a degree, signed);
//   rsp channel returns min_temp / max_temp over all defined bins, times four
//   (508 / -512 when no bin is defined). each item gives exactly one result.
//   csr_we writes samples_per_bin and restarts the history as reset does;
//   write it only while no item is in flight.
// item sequence:
//   one ram read, one multiply, a bit-serial divide, one or two ram writes,
//   then a pass over all 256 bins through the single ram read port, which
//   dominates. req_stall is high from acceptance until the result is loaded,
//   so one item is processed at a time.
// reset:
//   synchronous, active high; samples_per_bin returns to 338, all bins are
//   marked undefined through per-bin valid flops, the bin pointer goes to 0.
// stall:
//   the result sits in an output register until taken; a new item is accepted
//   meanwhile, and its result waits in the final step if the old one is still
//   held.
module binned_mean_min_max_history_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [bmmh_pkg::TEMP_W-1:0]  req_temperature,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [bmmh_pkg::TEMP_W-1:0]  rsp_min_temp,
   output logic signed [bmmh_pkg::TEMP_W-1:0]  rsp_max_temp,
   input  logic                                csr_we,
   input  logic [bmmh_pkg::SPB_W-1:0]          csr_wdata
);

   localparam int AW = bmmh_pkg::BIN_AW;
   localparam int BW = bmmh_pkg::BIN_W;
   localparam int SW = bmmh_pkg::SPB_W;

   bmmh_pkg::state_type              state_ff, state_in;
   logic [SW-1:0]                    spb_ff;
   logic [SW-1:0]                    sib_ff, sib_in;
   logic [AW-1:0]                    ptr_ff, ptr_in;
   logic [bmmh_pkg::BINS-1:0]        vld_ff;
   logic signed [bmmh_pkg::TEMP_W-1:0] temp_ff;
   logic                             neg_ff, neg_in;
   logic [bmmh_pkg::SCAN_W-1:0]      scan_ff, scan_in;
   logic                             scan_last;
   logic                             pend_ff;
   logic signed [BW-1:0]             lo_ff, lo_in;
   logic signed [BW-1:0]             hi_ff, hi_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [bmmh_pkg::TEMP_W-1:0] min_ff, max_ff;
   logic                             load_rsp;

   // bin ram
   logic signed [BW-1:0]             bin_mem [bmmh_pkg::BINS];
   logic [AW-1:0]                    rd_addr;
   logic signed [BW-1:0]             rd_data_ff;
   logic                             rd_vld_ff;
   logic                             mem_we;
   logic [AW-1:0]                    mem_waddr;
   logic signed [BW-1:0]             mem_wdata;

   // arithmetic
   logic [SW-1:0]                    limit;
   logic signed [BW-1:0]             seed;
   logic signed [BW-1:0]             cur_bin;
   logic signed [24:0]               prod;
   logic signed [27:0]               acc;
   logic [27:0]                      acc_mag;
   logic [bmmh_pkg::ACC_W-3:0]       q4;
   logic [BW-1:0]                    mean_mag;
   logic signed [BW-1:0]             mean;
   logic [SW:0]                      sib_next;
   logic [AW-1:0]                    ptr_next;

   bmmh_pkg::div_req_type            div_req;
   bmmh_pkg::div_rsp_type            div_rsp;

   bmmh_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // zero samples per bin acts as one
   assign limit = (spb_ff == '0) ? SW'(1) : spb_ff;
   assign seed  = bmmh_pkg::seed_bin(temp_ff);

   // scan index past the last bin
   assign scan_last = (scan_ff == (bmmh_pkg::SCAN_W)'(bmmh_pkg::BINS));

   // fold sample into current bin: 4 * bin * count + sample
   always_comb begin
      cur_bin = rd_vld_ff ? rd_data_ff : seed;
      prod    = cur_bin * $signed({1'b0, sib_ff});
      acc     = (28'(prod) <<< 2) + 28'(temp_ff);
      acc_mag = acc[27] ? (~acc + 1'b1) : acc;
   end

   // quotient / 4, clipped and signed
   always_comb begin
      q4       = div_rsp.quotient[bmmh_pkg::ACC_W-1:2];
      mean_mag = (q4 > (bmmh_pkg::ACC_W-2)'(bmmh_pkg::BIN_MAX))
                 ? BW'(bmmh_pkg::BIN_MAX) : q4[BW-1:0];
      mean     = neg_ff ? $signed(~mean_mag + 1'b1) : $signed(mean_mag);
      sib_next = {1'b0, sib_ff} + 1'b1;
      ptr_next = (ptr_ff == AW'(bmmh_pkg::BINS - 1)) ? '0 : ptr_ff + 1'b1;
   end

   assign load_rsp = (state_ff == bmmh_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in         = state_ff;
      sib_in           = sib_ff;
      ptr_in           = ptr_ff;
      neg_in           = neg_ff;
      scan_in          = scan_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      rd_addr          = ptr_ff;
      mem_we           = 1'b0;
      mem_waddr        = ptr_ff;
      mem_wdata        = mean;
      div_req.start    = 1'b0;
      div_req.dividend = acc_mag[bmmh_pkg::ACC_W-1:0];
      div_req.divisor  = sib_next[SW-1:0];
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      case (state_ff)
         bmmh_pkg::ST_IDLE: begin
            if (req_valid) state_in = bmmh_pkg::ST_READ;
         end
         bmmh_pkg::ST_READ: begin
            lo_in    = bmmh_pkg::BIN_MAX;
            hi_in    = bmmh_pkg::UNDEF_BIN;
            state_in = bmmh_pkg::ST_MULT;
         end
         bmmh_pkg::ST_MULT: begin
            div_req.start = 1'b1;
            neg_in        = acc[27];
            state_in      = bmmh_pkg::ST_DIVIDE;
         end
         bmmh_pkg::ST_DIVIDE: begin
            if (div_rsp.done) state_in = bmmh_pkg::ST_WRITE;
         end
         bmmh_pkg::ST_WRITE: begin
            mem_we  = 1'b1;
            scan_in = '0;
            if (sib_next >= {1'b0, limit}) begin
               sib_in   = '0;
               ptr_in   = ptr_next;
               state_in = bmmh_pkg::ST_SEED;
            end else begin
               sib_in   = sib_next[SW-1:0];
               state_in = bmmh_pkg::ST_SCAN;
            end
         end
         bmmh_pkg::ST_SEED: begin
            mem_we    = 1'b1;
            mem_wdata = seed;
            state_in  = bmmh_pkg::ST_SCAN;
         end
         bmmh_pkg::ST_SCAN: begin
            rd_addr = scan_ff[AW-1:0];
            scan_in = scan_ff + 1'b1;
            if (pend_ff && rd_vld_ff) begin
               if (rd_data_ff < lo_ff) lo_in = rd_data_ff;
               if (rd_data_ff > hi_ff) hi_in = rd_data_ff;
            end
            if (scan_last) state_in = bmmh_pkg::ST_FINISH;
         end
         bmmh_pkg::ST_FINISH: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = bmmh_pkg::ST_IDLE;
            end
         end
         default: state_in = bmmh_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmmh_pkg::ST_IDLE;
         spb_ff       <= bmmh_pkg::SPB_RESET;
         sib_ff       <= bmmh_pkg::SPB_RESET - 1'b1;
         ptr_ff       <= '0;
         vld_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (csr_we) begin
         spb_ff <= csr_wdata;
         sib_ff <= (csr_wdata == '0) ? '0 : csr_wdata - 1'b1;
         ptr_ff <= '0;
         vld_ff <= '0;
      end else begin
         state_ff     <= state_in;
         sib_ff       <= sib_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= (state_ff == bmmh_pkg::ST_SCAN) && !scan_last;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we) vld_ff[mem_waddr] <= 1'b1;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == bmmh_pkg::ST_IDLE) temp_ff <= req_temperature;
      neg_ff  <= neg_in;
      scan_ff <= scan_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      if (load_rsp) begin
         min_ff <= {lo_ff, 2'b00};
         max_ff <= {hi_ff, 2'b00};
      end
   end

   // bin ram: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) bin_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= bin_mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
   end

   assign req_stall    = (state_ff != bmmh_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_min_temp = min_ff;
   assign rsp_max_temp = max_ff;

   // never store the undefined marker as a bin value
   a_no_undef_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> mem_wdata != bmmh_pkg::UNDEF_BIN)
      else $error("undefined marker written to bin ram");

   // divider finishes only while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == bmmh_pkg::ST_DIVIDE)
      else $error("divider done outside divide step");

   // sample count stays below the bin size between items
   a_sib_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == bmmh_pkg::ST_IDLE |-> {1'b0, sib_ff} < {1'b0, limit})
      else $error("sample count reached bin size");

   // any defined bin found means min does not exceed max
   a_lo_hi_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmmh_pkg::ST_FINISH && hi_ff != bmmh_pkg::UNDEF_BIN) |-> lo_ff <= hi_ff)
      else $error("scan min above max");

   // a new result appears only out of the final step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bmmh_pkg::ST_FINISH))
      else $error("result raised outside final step");

endmodule

[sim/tb_binned_mean_min_max_history_core.sv]
// testbench for binned_mean_min_max_history_core: random and directed temperature items,
// bursty sender, stalling receiver, predicted min / max checked item by item
// depends on rtl/bmmh_pkg.sv and the core with its divider
module tb_binned_mean_min_max_history_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF  = 5;
   localparam int RESET_CYC = 11;
   localparam int LIMIT_CYC = 3_000_000;
   localparam int SETTLE    = 300;
   localparam int BIN_FLOOR = -127;

   typedef struct {
      logic signed [bmmh_pkg::TEMP_W-1:0] min_temp;
      logic signed [bmmh_pkg::TEMP_W-1:0] max_temp;
   } temp_range_type;

   // dut ports
   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [bmmh_pkg::TEMP_W-1:0] req_temperature = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [bmmh_pkg::TEMP_W-1:0] rsp_min_temp;
   logic signed [bmmh_pkg::TEMP_W-1:0] rsp_max_temp;
   logic                               csr_we = 1'b0;
   logic [bmmh_pkg::SPB_W-1:0]         csr_wdata = '0;

   // stimulus and scoreboard storage
   logic signed [bmmh_pkg::TEMP_W-1:0] pending_samples[$];
   temp_range_type                     expected_ranges[$];
   int                                 err_count = 0;
   int                                 cycle_count = 0;
   int                                 walk_center = 0;

   // driver bookkeeping
   logic req_fire = 1'b0;
   int   burst_left = 1;
   int   send_gap = 0;
   int   stall_left = 0;

   // history predictor state
   int bin_avg [bmmh_pkg::BINS];
   int fill_count;
   int bin_ptr;
   int spb_model;

   binned_mean_min_max_history_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_temperature (req_temperature),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_min_temp    (rsp_min_temp),
      .rsp_max_temp    (rsp_max_temp),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // clip a bin value so that the undefined marker is never produced
   function automatic int clip_bin(longint v);
      if (v > bmmh_pkg::BIN_MAX) return int'(bmmh_pkg::BIN_MAX);
      if (v < BIN_FLOOR) return BIN_FLOOR;
      return int'(v);
   endfunction

   function automatic int bin_limit();
      return (spb_model == 0) ? 1 : spb_model;
   endfunction

   // mark every bin undefined, pointer back to the first bin
   function automatic void restart_history();
      for (int i = 0; i < bmmh_pkg::BINS; i++) bin_avg[i] = int'(bmmh_pkg::UNDEF_BIN);
      bin_ptr    = 0;
      fill_count = bin_limit() - 1;
   endfunction

   // fold one sample into the history and return the scaled min / max
   function automatic temp_range_type fold_sample(logic signed [bmmh_pkg::TEMP_W-1:0] sample);
      int             t;
      int             p;
      int             lo;
      int             hi;
      longint         acc;
      temp_range_type r;
      t = int'(sample);
      p = bin_ptr % bmmh_pkg::BINS;
      if (bin_avg[p] == bmmh_pkg::UNDEF_BIN) bin_avg[p] = clip_bin(t / 4);
      acc = 4 * longint'(bin_avg[p]) * longint'(fill_count) + t;
      fill_count++;
      bin_avg[p] = clip_bin((acc / longint'(fill_count)) / 4);
      // bin full: advance and seed the next bin with this sample
      if (fill_count >= bin_limit()) begin
         p = (p + 1) % bmmh_pkg::BINS;
         fill_count = 0;
         bin_avg[p] = clip_bin(t / 4);
      end
      bin_ptr = p;
      lo = int'(bmmh_pkg::BIN_MAX);
      hi = int'(bmmh_pkg::UNDEF_BIN);
      for (int i = 0; i < bmmh_pkg::BINS; i++) begin
         if (bin_avg[i] != bmmh_pkg::UNDEF_BIN) begin
            if (bin_avg[i] < lo) lo = bin_avg[i];
            if (bin_avg[i] > hi) hi = bin_avg[i];
         end
      end
      r.min_temp = (bmmh_pkg::TEMP_W)'(lo * 4);
      r.max_temp = (bmmh_pkg::TEMP_W)'(hi * 4);
      return r;
   endfunction

   // mix of extremes, uniform noise and a slow drifting trace
   function automatic logic signed [bmmh_pkg::TEMP_W-1:0] draw_temperature();
      int pick;
      int v;
      pick = int'($urandom_range(0, 9));
      if (pick == 0) begin
         case ($urandom_range(0, 3))
            0: v = -512;
            1: v = 511;
            2: v = -511;
            default: v = 510;
         endcase
      end else if (pick < 5) begin
         v = int'($urandom_range(0, 1023)) - 512;
      end else begin
         walk_center = walk_center + int'($urandom_range(0, 24)) - 12;
         if (walk_center > 511) walk_center = 511;
         if (walk_center < -512) walk_center = -512;
         v = walk_center;
      end
      return (bmmh_pkg::TEMP_W)'(v);
   endfunction

   // predictor: tracks reset, register writes and accepted items
   always @(posedge clock) begin : predictor
      req_fire <= req_valid && !req_stall && !reset;
      if (reset) begin
         spb_model = int'(bmmh_pkg::SPB_RESET);
         restart_history();
      end else begin
         if (csr_we) begin
            spb_model = int'(csr_wdata);
            restart_history();
         end
         if (req_valid && !req_stall) expected_ranges.push_back(fold_sample(req_temperature));
      end
   end

   // driver: bursts of items with random gaps, payload held while stalled
   always @(negedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // item still waiting for acceptance
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
         req_valid       <= 1'b1;
         req_temperature <= pending_samples.pop_front();
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = int'($urandom_range(1, 8));
            send_gap   = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 350));
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver stall pattern: free-running stretches of stall and no stall
   always @(negedge clock) begin : stall_gen
      if (stall_left > 0) begin
         stall_left--;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_left = int'($urandom_range(1, 300));
      end else begin
         rsp_stall  <= ($urandom_range(0, 2) != 0);
         stall_left = int'($urandom_range(1, 40));
      end
   end

   // monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin : monitor
      temp_range_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ranges.size() == 0) begin
            $error("unexpected result: min_temp %0d max_temp %0d", rsp_min_temp, rsp_max_temp);
            err_count++;
         end else begin
            want = expected_ranges.pop_front();
            if (rsp_min_temp !== want.min_temp) begin
               $error("min_temp mismatch: expected %0d, actual %0d", want.min_temp, rsp_min_temp);
               err_count++;
            end
            if (rsp_max_temp !== want.max_temp) begin
               $error("max_temp mismatch: expected %0d, actual %0d", want.max_temp, rsp_max_temp);
               err_count++;
            end
         end
      end
   end

   // run watchdog
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > LIMIT_CYC) begin
         $display("tb_binned_mean_min_max_history_core: done, errors");
         $finish;
      end
   end

   // wait until every item has been sent and answered; checked at the rising
   // edge, where queue and valid are never caught between driver updates
   task automatic wait_idle();
      @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_ranges.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_samples_per_bin(logic [bmmh_pkg::SPB_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic queue_one(int v);
      pending_samples.push_back((bmmh_pkg::TEMP_W)'(v));
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) pending_samples.push_back(draw_temperature());
   endtask

   // stimulus sequence
   initial begin : stimulus
      repeat (RESET_CYC) @(negedge clock);
      reset <= 1'b0;

      // default bin size: saturating seed into an empty bin, the other extreme, then small values around zero
      queue_one(-512);
      queue_one(511);
      queue_one(0);
      queue_one(-1);
      queue_one(1);
      queue_one(-3);
      queue_one(3);
      queue_one(-4);
      queue_one(4);

      // zero samples per bin acts as one
      write_samples_per_bin(16'd0);
      queue_one(511);
      queue_one(-512);
      queue_one(-2);
      queue_one(2);
      queue_one(-5);
      queue_one(6);

      write_samples_per_bin(16'd1);
      queue_one(100);
      queue_one(-100);
      queue_one(511);
      queue_one(-512);

      // widest bin
      write_samples_per_bin(16'hFFFF);
      queue_one(511);
      queue_one(511);
      queue_one(-512);
      queue_one(0);
      queue_one(7);
      queue_one(-7);

      // one sample per bin, long enough to wrap the pointer
      write_samples_per_bin(16'd1);
      queue_random(300);
      write_samples_per_bin(16'd2);
      queue_random(100);
      write_samples_per_bin(16'd3);
      queue_random(60);
      write_samples_per_bin((bmmh_pkg::SPB_W)'($urandom_range(4, 20)));
      queue_random(80);
      write_samples_per_bin(bmmh_pkg::SPB_RESET);
      queue_random(60);
      write_samples_per_bin(16'hFFFF);
      queue_random(40);
      write_samples_per_bin(16'd0);
      queue_random(40);
      write_samples_per_bin((bmmh_pkg::SPB_W)'($urandom_range(0, 65535)));
      queue_random(40);
      write_samples_per_bin((bmmh_pkg::SPB_W)'($urandom_range(1, 8)));
      queue_random(30);

      wait_idle();
      repeat (SETTLE) @(posedge clock);
      if (expected_ranges.size() != 0) begin
         $error("%0d results never arrived", expected_ranges.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("tb_binned_mean_min_max_history_core: done, clean");
      end else begin
         $display("tb_binned_mean_min_max_history_core: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
rtl/bmmh_pkg.sv
rtl/bmmh_div.sv
rtl/binned_mean_min_max_history_core.sv
sim/tb_binned_mean_min_max_history_core.sv
